// ===== design/tts_pkg.sv =====
// Shared types, constants and saturation helper for the tridiagonal solver.
package tts_pkg;

    localparam int Q_W       = 32;
    localparam int ROW_IDX_W = 6;
    // Quotient bits produced by the divider; larger quotients saturate anyway
    localparam int DIV_QB    = 33;

    localparam logic signed [Q_W-1:0] QMAX = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0] QMIN = 32'sh8000_0000;

    // Divider status toward the sequencer
    typedef struct packed {
        logic done;
        logic err;
    } div_status_t;

    // Saturated value plus overflow mark
    typedef struct packed {
        logic signed [Q_W-1:0] val;
        logic                  ovf;
    } sat_t;

    // Clamp a 64-bit signed value into 32 bits
    function automatic sat_t sat32(input logic signed [63:0] v);
        sat_t r;
        if ((v[63:31] == {33{1'b0}}) || (v[63:31] == {33{1'b1}})) begin
            r.val = v[Q_W-1:0];
            r.ovf = 1'b0;
        end
        else begin
            r.val = v[63] ? QMIN : QMAX;
            r.ovf = 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== design/tridiagonal_thomas_solver.sv =====
// Tridiagonal solver top level: Thomas sweep sequencer over a shared multiplier and divider.
// Forward row: a read and two multiplies (skipped on the first row), then two passes
// of the 33-step divider; one row is taken at a time.
// Last row: its forward work, then the results one by one from the highest index down.
// A new system is taken once the final result is loaded into the output register.
// Reset (rst_n, asynchronous): idle, no result pending, row count and error cleared.
module tridiagonal_thomas_solver import tts_pkg::*; #(
    parameter int MAX_ROWS  = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [Q_W-1:0]       sub_coef,
    input  logic signed [Q_W-1:0]       diag_coef,
    input  logic signed [Q_W-1:0]       super_coef,
    input  logic signed [Q_W-1:0]       rhs,
    input  logic                        last_row,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [Q_W-1:0]       solution,
    output logic [ROW_IDX_W-1:0]        row_index,
    output logic                        last_result,
    output logic                        error
);

    localparam int IDX_W = $clog2(MAX_ROWS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ROWS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_F_RD,
        S_F_MA,
        S_F_MB,
        S_F_MC,
        S_DC_GO,
        S_DC_WAIT,
        S_DO_GO,
        S_DO_WAIT,
        S_B_RD,
        S_B_MA,
        S_B_ADD,
        S_B_OUT
    } seq_state_t;

    seq_state_t                 state_reg, state_next;
    logic [IDX_W-1:0]           row_count_reg, row_count_next;
    logic                       err_reg, err_next;
    logic [IDX_W-1:0]           ptr_reg, ptr_next;
    logic signed [Q_W-1:0]      a_reg, a_next;
    logic signed [Q_W-1:0]      d_reg, d_next;
    logic signed [Q_W-1:0]      c_reg, c_next;
    logic signed [Q_W-1:0]      f_reg, f_next;
    logic                       last_reg, last_next;
    logic signed [Q_W-1:0]      den_reg, den_next;
    logic signed [Q_W-1:0]      onum_reg, onum_next;
    logic signed [63:0]         prod_reg, prod_next;
    logic signed [Q_W-1:0]      opnd_reg, opnd_next;
    logic signed [Q_W-1:0]      x_reg, x_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [Q_W-1:0]      solution_reg, solution_next;
    logic [ROW_IDX_W-1:0]       row_index_reg, row_index_next;
    logic                       last_result_reg, last_result_next;
    logic                       error_reg, error_next;

    logic                       forced;
    logic                       eff_last;
    logic signed [Q_W-1:0]      mul_a, mul_b;
    logic signed [63:0]         mul_p;
    logic signed [63:0]         prod_sh;
    sat_t                       den_sat, onum_sat, x_sat;
    logic [IDX_W+ROW_IDX_W-1:0] ptr_wide;

    logic                       div_start;
    logic signed [Q_W:0]        div_num;
    logic signed [Q_W-1:0]      div_quo;
    div_status_t                div_st;

    logic                       coef_we, off_we;
    logic [IDX_W-1:0]           raddr;
    logic [Q_W-1:0]             coef_rdata, off_rdata;

    // Sweep coefficient and offset stores
    tts_ram #(.WIDTH(Q_W), .DEPTH(MAX_ROWS)) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (ptr_reg),
        .wdata (div_quo),
        .raddr (raddr),
        .rdata (coef_rdata)
    );

    tts_ram #(.WIDTH(Q_W), .DEPTH(MAX_ROWS)) u_off_ram (
        .clk   (clk),
        .we    (off_we),
        .waddr (ptr_reg),
        .wdata (div_quo),
        .raddr (raddr),
        .rdata (off_rdata)
    );

    // Shared divider
    tts_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (den_reg),
        .quo    (div_quo),
        .status (div_st)
    );

    // Capacity full forces the last row
    assign forced   = !last_row && (row_count_reg == LAST_IDX);
    assign eff_last = last_row || forced;

    // Shared multiplier, registered into prod_reg
    always_comb
    begin
        case (state_reg)
            S_F_MA:
            begin
                mul_a = a_reg;
                mul_b = $signed(coef_rdata);
            end
            S_B_MA:
            begin
                mul_a = $signed(coef_rdata);
                mul_b = x_reg;
            end
            default:
            begin
                mul_a = a_reg;
                mul_b = opnd_reg;
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign prod_sh = prod_reg >>> FRAC_BITS;

    // Sums and difference after the product, each saturated
    assign den_sat  = sat32(prod_sh + {{32{d_reg[Q_W-1]}}, d_reg});
    assign onum_sat = sat32($signed({{32{f_reg[Q_W-1]}}, f_reg}) - prod_sh);
    assign x_sat    = sat32(prod_sh + {{32{opnd_reg[Q_W-1]}}, opnd_reg});

    // Divider start and operand, RAM read address and write enables
    assign div_start = (state_reg == S_DC_GO) || (state_reg == S_DO_GO);
    assign div_num   = (state_reg == S_DO_GO) ? {onum_reg[Q_W-1], onum_reg}
                                              : ((Q_W+1)'(0) - {c_reg[Q_W-1], c_reg});
    assign raddr     = (state_reg == S_F_RD) ? (ptr_reg - IDX_W'(1)) : ptr_reg;
    assign coef_we   = (state_reg == S_DC_WAIT) && div_st.done;
    assign off_we    = (state_reg == S_DO_WAIT) && div_st.done;
    assign ptr_wide  = {{ROW_IDX_W{1'b0}}, ptr_reg};

    // Sequencer next state
    always_comb
    begin
        state_next       = state_reg;
        row_count_next   = row_count_reg;
        err_next         = err_reg;
        ptr_next         = ptr_reg;
        a_next           = a_reg;
        d_next           = d_reg;
        c_next           = c_reg;
        f_next           = f_reg;
        last_next        = last_reg;
        den_next         = den_reg;
        onum_next        = onum_reg;
        prod_next        = prod_reg;
        opnd_next        = opnd_reg;
        x_next           = x_reg;
        out_valid_next   = out_valid_reg;
        solution_next    = solution_reg;
        row_index_next   = row_index_reg;
        last_result_next = last_result_reg;
        error_next       = error_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    a_next    = sub_coef;
                    d_next    = diag_coef;
                    c_next    = eff_last ? '0 : super_coef;
                    f_next    = rhs;
                    last_next = eff_last;
                    ptr_next  = row_count_reg;
                    err_next  = err_reg | forced;
                    if (row_count_reg == '0)
                    begin
                        den_next   = diag_coef;
                        onum_next  = rhs;
                        state_next = S_DC_GO;
                    end
                    else
                    begin
                        state_next = S_F_RD;
                    end
                end
            end
            S_F_RD:
            begin
                state_next = S_F_MA;
            end
            S_F_MA:
            begin
                prod_next  = mul_p;
                opnd_next  = $signed(off_rdata);
                state_next = S_F_MB;
            end
            S_F_MB:
            begin
                den_next   = den_sat.val;
                err_next   = err_reg | den_sat.ovf;
                prod_next  = mul_p;
                state_next = S_F_MC;
            end
            S_F_MC:
            begin
                onum_next  = onum_sat.val;
                err_next   = err_reg | onum_sat.ovf;
                state_next = S_DC_GO;
            end
            S_DC_GO:
            begin
                state_next = S_DC_WAIT;
            end
            S_DC_WAIT:
            begin
                if (div_st.done)
                begin
                    err_next   = err_reg | div_st.err;
                    state_next = S_DO_GO;
                end
            end
            S_DO_GO:
            begin
                state_next = S_DO_WAIT;
            end
            S_DO_WAIT:
            begin
                if (div_st.done)
                begin
                    err_next = err_reg | div_st.err;
                    x_next   = div_quo;
                    if (last_reg)
                    begin
                        state_next = S_B_OUT;
                    end
                    else
                    begin
                        row_count_next = ptr_reg + IDX_W'(1);
                        state_next     = S_IDLE;
                    end
                end
            end
            S_B_RD:
            begin
                state_next = S_B_MA;
            end
            S_B_MA:
            begin
                prod_next  = mul_p;
                opnd_next  = $signed(off_rdata);
                state_next = S_B_ADD;
            end
            S_B_ADD:
            begin
                x_next     = x_sat.val;
                err_next   = err_reg | x_sat.ovf;
                state_next = S_B_OUT;
            end
            S_B_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    solution_next    = x_reg;
                    row_index_next   = ptr_wide[ROW_IDX_W-1:0];
                    last_result_next = (ptr_reg == '0);
                    error_next       = err_reg;
                    if (ptr_reg == '0)
                    begin
                        // system done: ready for a new one
                        row_count_next = '0;
                        err_next       = 1'b0;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg - IDX_W'(1);
                        state_next = S_B_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            row_count_reg   <= '0;
            err_reg         <= 1'b0;
            ptr_reg         <= '0;
            a_reg           <= '0;
            d_reg           <= '0;
            c_reg           <= '0;
            f_reg           <= '0;
            last_reg        <= 1'b0;
            den_reg         <= '0;
            onum_reg        <= '0;
            prod_reg        <= '0;
            opnd_reg        <= '0;
            x_reg           <= '0;
            out_valid_reg   <= 1'b0;
            solution_reg    <= '0;
            row_index_reg   <= '0;
            last_result_reg <= 1'b0;
            error_reg       <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            row_count_reg   <= row_count_next;
            err_reg         <= err_next;
            ptr_reg         <= ptr_next;
            a_reg           <= a_next;
            d_reg           <= d_next;
            c_reg           <= c_next;
            f_reg           <= f_next;
            last_reg        <= last_next;
            den_reg         <= den_next;
            onum_reg        <= onum_next;
            prod_reg        <= prod_next;
            opnd_reg        <= opnd_next;
            x_reg           <= x_next;
            out_valid_reg   <= out_valid_next;
            solution_reg    <= solution_next;
            row_index_reg   <= row_index_next;
            last_result_reg <= last_result_next;
            error_reg       <= error_next;
        end
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign solution    = solution_reg;
    assign row_index   = row_index_reg;
    assign last_result = last_result_reg;
    assign error       = error_reg;

endmodule

// ===== design/tts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/tts_div.sv =====
// Radix-2 restoring divider: (num << FRAC_BITS) / den, truncated, saturated to 32 bits.
module tts_div import tts_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [Q_W:0]   num,
    input  logic signed [Q_W-1:0] den,
    output logic signed [Q_W-1:0] quo,
    output div_status_t           status
);

    localparam int NW = Q_W + FRAC_BITS;
    localparam int HW = NW - DIV_QB;
    localparam logic [5:0] CNT_LAST = 6'(DIV_QB - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIN
    } div_state_t;

    div_state_t             state_reg, state_next;
    logic [5:0]             cnt_reg, cnt_next;
    logic [Q_W-1:0]         rem_reg, rem_next;
    logic [DIV_QB-1:0]      low_reg, low_next;
    logic [DIV_QB-1:0]      q_reg, q_next;
    logic [Q_W-1:0]         dmag_reg, dmag_next;
    logic                   neg_reg, neg_next;
    logic signed [Q_W-1:0]  quo_reg, quo_next;
    logic                   done_reg, done_next;
    logic                   err_reg, err_next;

    logic [Q_W:0]           num_abs;
    logic [Q_W:0]           den_abs;
    logic [NW-1:0]          n_full;
    logic [Q_W-1:0]         hi_ext;
    logic [DIV_QB-1:0]      trial;
    logic                   ge;

    // Operand magnitudes and the scaled dividend
    assign num_abs = num[Q_W] ? ((Q_W+1)'(0) - num) : num;
    assign den_abs = den[Q_W-1] ? ((Q_W+1)'(0) - {den[Q_W-1], den}) : {den[Q_W-1], den};
    assign n_full  = {num_abs[Q_W-1:0], {FRAC_BITS{1'b0}}};
    assign hi_ext  = {{(Q_W-HW){1'b0}}, n_full[NW-1:DIV_QB]};

    // One shift-subtract step
    assign trial = {rem_reg, low_reg[DIV_QB-1]};
    assign ge    = (trial >= {1'b0, dmag_reg});

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        low_next   = low_reg;
        q_next     = q_reg;
        dmag_next  = dmag_reg;
        neg_next   = neg_reg;
        quo_next   = quo_reg;
        done_next  = 1'b0;
        err_next   = err_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    neg_next  = num[Q_W] ^ den[Q_W-1];
                    dmag_next = den_abs[Q_W-1:0];
                    if (den == '0)
                    begin
                        // zero divisor: result follows the numerator sign
                        done_next = 1'b1;
                        err_next  = 1'b1;
                        if (num[Q_W])
                        begin
                            quo_next = QMIN;
                        end
                        else if (num != '0)
                        begin
                            quo_next = QMAX;
                        end
                        else
                        begin
                            quo_next = '0;
                        end
                    end
                    else if (hi_ext >= den_abs[Q_W-1:0])
                    begin
                        // quotient needs more than DIV_QB bits
                        done_next = 1'b1;
                        err_next  = 1'b1;
                        quo_next  = (num[Q_W] ^ den[Q_W-1]) ? QMIN : QMAX;
                    end
                    else
                    begin
                        err_next   = 1'b0;
                        rem_next   = hi_ext;
                        low_next   = n_full[DIV_QB-1:0];
                        q_next     = '0;
                        cnt_next   = '0;
                        state_next = S_RUN;
                    end
                end
            end
            S_RUN:
            begin
                rem_next = ge ? Q_W'(trial - {1'b0, dmag_reg}) : trial[Q_W-1:0];
                low_next = {low_reg[DIV_QB-2:0], 1'b0};
                q_next   = {q_reg[DIV_QB-2:0], ge};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (!neg_reg)
                begin
                    if (q_reg[DIV_QB-1] | q_reg[Q_W-1])
                    begin
                        quo_next = QMAX;
                        err_next = 1'b1;
                    end
                    else
                    begin
                        quo_next = q_reg[Q_W-1:0];
                    end
                end
                else
                begin
                    if (q_reg[DIV_QB-1] | (q_reg[Q_W-1] & (|q_reg[Q_W-2:0])))
                    begin
                        quo_next = QMIN;
                        err_next = 1'b1;
                    end
                    else
                    begin
                        quo_next = Q_W'(0) - q_reg[Q_W-1:0];
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            low_reg   <= '0;
            q_reg     <= '0;
            dmag_reg  <= '0;
            neg_reg   <= 1'b0;
            quo_reg   <= '0;
            done_reg  <= 1'b0;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
            low_reg   <= low_next;
            q_reg     <= q_next;
            dmag_reg  <= dmag_next;
            neg_reg   <= neg_next;
            quo_reg   <= quo_next;
            done_reg  <= done_next;
            err_reg   <= err_next;
        end
    end

    assign quo         = quo_reg;
    assign status.done = done_reg;
    assign status.err  = err_reg;

endmodule

// ===== design/tts_checker.sv =====
// Port-level checker for the tridiagonal solver, bound to the top level.
module tts_checker import tts_pkg::*; (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic signed [Q_W-1:0] solution,
    input logic [ROW_IDX_W-1:0]  row_index,
    input logic                  last_result,
    input logic                  error
);

    // Reset leaves the block idle with no result pending
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> (!out_valid && !in_stall))
        else $error("block not idle after reset");

    // One row at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken on consecutive cycles");

    // While a non-final result is pending, the system is still in progress
    a_busy_midsystem: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_result) |-> in_stall)
        else $error("new row taken before the system finished");

    // Final result always carries index zero
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_result) |-> (row_index == '0))
        else $error("final result with nonzero index");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(solution)
            && $stable(row_index) && $stable(last_result) && $stable(error)))
        else $error("stalled result changed");

endmodule

bind tridiagonal_thomas_solver tts_checker u_tts_checker (.*);
